>>> hdl/rfps_pkg.sv
// Shared types, constants and pattern tables for the RGB fade PWM sequencer.
`default_nettype none

package rfps_pkg;

  // Default build values
  localparam int unsigned RAMP_STEPS_DEF    = 254;
  localparam int unsigned PWM_INCREMENT_DEF = 4;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam logic [7:0]  FAST_RESET = 8'd30;
  localparam logic [7:0]  SLOW_RESET = 8'd150;

  // Input beat kinds
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_CHAR = 1'b1;

  // Pattern selection characters
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_THREE = 8'h33;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FAST_STEP = 2'd0,
    REG_SLOW_STEP = 2'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PAT_XFADE  = 3'd0,  // G>R>B>G
    PAT_SINGLE = 3'd1,  // R, G, B alone
    PAT_GB     = 3'd2,  // G>B>G
    PAT_GBR    = 3'd3,  // G>B>R>G
    PAT_IDLE   = 3'd4
  } pattern_e;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2,
    CH_NONE  = 2'd3
  } chan_e;

  // Channel levels, index 0 red, 1 green, 2 blue
  typedef logic [2:0][7:0] levels_t;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_char;
  } in_t;

  typedef struct packed {
    logic       red_pin;
    logic       green_pin;
    logic       blue_pin;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
  } out_t;

  // Channel that ramps up in a phase
  function automatic chan_e rise_chan(pattern_e pat, logic [1:0] ph);
    chan_e c;
    c = CH_NONE;
    case (pat)
      PAT_XFADE: begin
        case (ph)
          2'd0:    c = CH_RED;
          2'd1:    c = CH_BLUE;
          2'd2:    c = CH_GREEN;
          default: c = CH_NONE;
        endcase
      end
      PAT_SINGLE: begin
        case (ph)
          2'd0:    c = CH_RED;
          2'd1:    c = CH_GREEN;
          2'd2:    c = CH_BLUE;
          default: c = CH_NONE;
        endcase
      end
      PAT_GB: begin
        case (ph)
          2'd0:    c = CH_BLUE;
          2'd1:    c = CH_GREEN;
          default: c = CH_NONE;
        endcase
      end
      PAT_GBR: begin
        case (ph)
          2'd0:    c = CH_BLUE;
          2'd1:    c = CH_RED;
          2'd2:    c = CH_GREEN;
          default: c = CH_NONE;
        endcase
      end
      default: c = CH_NONE;
    endcase
    return c;
  endfunction

  // Channel that ramps down in a phase
  function automatic chan_e fall_chan(pattern_e pat, logic [1:0] ph);
    chan_e c;
    c = CH_NONE;
    case (pat)
      PAT_XFADE: begin
        case (ph)
          2'd0:    c = CH_GREEN;
          2'd1:    c = CH_RED;
          2'd2:    c = CH_BLUE;
          default: c = CH_NONE;
        endcase
      end
      PAT_GB: begin
        case (ph)
          2'd0:    c = CH_GREEN;
          2'd1:    c = CH_BLUE;
          default: c = CH_NONE;
        endcase
      end
      PAT_GBR: begin
        case (ph)
          2'd0:    c = CH_GREEN;
          2'd1:    c = CH_BLUE;
          2'd2:    c = CH_RED;
          default: c = CH_NONE;
        endcase
      end
      default: c = CH_NONE;
    endcase
    return c;
  endfunction

  // Number of phases in one pass
  function automatic logic [1:0] phase_total(pattern_e pat);
    logic [1:0] n;
    case (pat)
      PAT_GB:  n = 2'd2;
      default: n = 2'd3;
    endcase
    return n;
  endfunction

  // Set the rising and falling channel levels for a step
  function automatic levels_t apply_levels(levels_t lv, pattern_e pat, logic [1:0] ph,
                                           logic [7:0] step, logic [7:0] ramp);
    levels_t r;
    chan_e   u;
    chan_e   d;
    r = lv;
    u = rise_chan(pat, ph);
    d = fall_chan(pat, ph);
    if (u != CH_NONE) r[u] = step;
    if (d != CH_NONE) r[d] = ramp - step;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/rfps_seq.sv
// Pattern sequencer: PWM counter, step timing, phase control and channel levels.
`default_nettype none

module rfps_seq #(
  parameter int unsigned RAMP_STEPS    = rfps_pkg::RAMP_STEPS_DEF,
  parameter int unsigned PWM_INCREMENT = rfps_pkg::PWM_INCREMENT_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           fire_i,
  input  wire rfps_pkg::in_t                  in_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [rfps_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [7:0]                     cfg_data_i,
  output rfps_pkg::levels_t                   res_levels_o,
  output logic [7:0]                          res_pwm_o
);
  import rfps_pkg::*;

  localparam logic [7:0] RAMP_W = 8'(RAMP_STEPS);
  localparam logic [7:0] INC_W  = 8'(PWM_INCREMENT);

  logic [7:0] fast_q, slow_q;
  logic [7:0] pwm_q, pwm_d;
  logic [7:0] char_q;
  pattern_e   pat_q, pat_d;
  logic [1:0] phase_q, phase_d;
  logic [7:0] step_q, step_d;
  logic [7:0] tick_q, tick_d;
  levels_t    lvl_q, lvl_d;

  // Values after a possible pass start
  pattern_e   pat_b;
  logic [1:0] phase_b;
  logic [7:0] step_b, tick_b, pwm_b;
  levels_t    lvl_b;
  logic [2:0] char_off;
  logic [7:0] step_len;
  logic [8:0] tick_inc, step_inc;
  logic [1:0] phase_inc;
  chan_e      done_chan;

  assign char_off = char_q[2:0] - CHAR_ZERO[2:0];

  // Pass start when idle
  always_comb begin
    pat_b   = pat_q;
    phase_b = phase_q;
    step_b  = step_q;
    tick_b  = tick_q;
    pwm_b   = pwm_q;
    lvl_b   = lvl_q;
    if (pat_q[2]) begin
      phase_b = 2'd0;
      step_b  = 8'd0;
      tick_b  = 8'd0;
      pwm_b   = 8'd0;
      lvl_b   = '0;
      if (char_q >= CHAR_ZERO && char_q <= CHAR_THREE) begin
        pat_b = pattern_e'(char_off);
        lvl_b = apply_levels('0, pat_b, 2'd0, 8'd0, RAMP_W);
      end else begin
        pat_b = PAT_IDLE;
      end
    end
  end

  // Result seen by this beat
  always_comb begin
    if (in_i.op == OP_CHAR) begin
      res_levels_o = lvl_q;
      res_pwm_o    = pwm_q;
    end else begin
      res_levels_o = lvl_b;
      res_pwm_o    = pwm_b + INC_W;
    end
  end

  // Step and phase advance after the tick
  assign step_len  = (pat_b == PAT_SINGLE) ? slow_q : fast_q;
  assign tick_inc  = {1'b0, tick_b} + 9'd1;
  assign step_inc  = {1'b0, step_b} + 9'd1;
  assign phase_inc = phase_b + 2'd1;
  assign done_chan = rise_chan(PAT_SINGLE, phase_b);

  always_comb begin
    pat_d   = pat_b;
    phase_d = phase_b;
    step_d  = step_b;
    tick_d  = tick_b;
    lvl_d   = lvl_b;
    pwm_d   = pwm_b + INC_W;
    if (!pat_b[2]) begin
      // zero length counts as one tick
      if (tick_inc < {1'b0, step_len} && step_len != 8'd0) begin
        tick_d = tick_inc[7:0];
      end else begin
        tick_d = 8'd0;
        if (step_inc < {1'b0, RAMP_W}) begin
          step_d = step_inc[7:0];
          lvl_d  = apply_levels(lvl_b, pat_b, phase_b, step_inc[7:0], RAMP_W);
        end else begin
          step_d = 8'd0;
          // single-color ramp is blanked at its end
          if (pat_b == PAT_SINGLE && done_chan != CH_NONE) lvl_d[done_chan] = 8'd0;
          if (phase_inc >= phase_total(pat_b) || phase_inc == 2'd0) begin
            phase_d = 2'd0;
            pat_d   = PAT_IDLE;
          end else begin
            phase_d = phase_inc;
            lvl_d   = apply_levels(lvl_d, pat_b, phase_inc, 8'd0, RAMP_W);
          end
        end
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_q <= FAST_RESET;
      slow_q <= SLOW_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_FAST_STEP: fast_q <= cfg_data_i;
        REG_SLOW_STEP: slow_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_q   <= 8'd0;
      char_q  <= 8'd0;
      pat_q   <= PAT_IDLE;
      phase_q <= 2'd0;
      step_q  <= 8'd0;
      tick_q  <= 8'd0;
      lvl_q   <= '0;
    end else if (fire_i) begin
      if (in_i.op == OP_CHAR) begin
        char_q <= in_i.rx_char;
      end else begin
        pwm_q   <= pwm_d;
        pat_q   <= pat_d;
        phase_q <= phase_d;
        step_q  <= step_d;
        tick_q  <= tick_d;
        lvl_q   <= lvl_d;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/rfps_out.sv
// Pin compare and result register with a skid stage.
`default_nettype none

module rfps_out (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,
  input  wire rfps_pkg::levels_t levels_i,
  input  wire logic [7:0]        pwm_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output rfps_pkg::out_t         out_data_o
);
  import rfps_pkg::*;

  out_t res;
  out_t main_q, skid_q;
  logic main_vld_q, skid_vld_q;
  logic out_fire;

  // Pins high while level is above the counter
  always_comb begin
    res.red_pin     = levels_i[CH_RED]   > pwm_i;
    res.green_pin   = levels_i[CH_GREEN] > pwm_i;
    res.blue_pin    = levels_i[CH_BLUE]  > pwm_i;
    res.red_level   = levels_i[CH_RED];
    res.green_level = levels_i[CH_GREEN];
    res.blue_level  = levels_i[CH_BLUE];
  end

  assign in_ready_o  = !skid_vld_q;
  assign out_valid_o = main_vld_q;
  assign out_data_o  = main_q;
  assign out_fire    = main_vld_q && out_ready_i;

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_fire) skid_vld_q <= 1'b0;
    end else if (fire_i) begin
      if (main_vld_q && !out_ready_i) skid_vld_q <= 1'b1;
      main_vld_q <= 1'b1;
    end else if (out_fire) begin
      main_vld_q <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_fire) main_q <= skid_q;
    end else if (fire_i) begin
      if (main_vld_q && !out_ready_i) skid_q <= res;
      else                            main_q <= res;
    end
  end

endmodule

`default_nettype wire

>>> hdl/rgb_fade_pwm_sequencer.sv
// Top level of the RGB fade PWM sequencer.
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i): each beat is either a PWM
//   tick (op = 0) or a received character (op = 1). A tick advances the PWM
//   counter and the fade sequencer; a character selects the pattern for the
//   next pass ('0'..'3'; anything else keeps all LEDs dark).
//   Output channel (out_valid_o/out_ready_i/out_data_o): one beat per input
//   beat, carrying the three pin states and the three duty levels.
//   Config channel (cfg_valid_i/cfg_ready_o): index 0 sets ticks per step for
//   the cross-fade patterns, index 1 for the single-color pattern. Always
//   ready; write only while the block is idle.
//   Results are registered (skid stage on a stall), one beat per cycle while
//   in_ready_o is high; the sequencer update is a single registered pass.
//   Reset clears the counter, levels and stored character, leaves no pattern
//   running and restores the step lengths to 30 and 150. When the receiver
//   stalls, the output register and a skid stage hold two results; once both
//   are full in_ready_o stays low until the receiver takes a beat.
`default_nettype none

module rgb_fade_pwm_sequencer #(
  parameter int unsigned RAMP_STEPS    = rfps_pkg::RAMP_STEPS_DEF,
  parameter int unsigned PWM_INCREMENT = rfps_pkg::PWM_INCREMENT_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire rfps_pkg::in_t                  in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output rfps_pkg::out_t                      out_data_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [rfps_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [7:0]                     cfg_data_i
);
  import rfps_pkg::*;

  logic       in_fire;
  levels_t    res_levels;
  logic [7:0] res_pwm;

  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;

  // Sequencer state and next-step logic
  rfps_seq #(
    .RAMP_STEPS    (RAMP_STEPS),
    .PWM_INCREMENT (PWM_INCREMENT)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (in_fire),
    .in_i         (in_data_i),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .res_levels_o (res_levels),
    .res_pwm_o    (res_pwm)
  );

  // Pin compare and output buffering
  rfps_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (in_fire),
    .levels_i    (res_levels),
    .pwm_i       (res_pwm),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// Testbench for the RGB fade PWM sequencer: ticks and characters checked against a predictor.
`timescale 1ns / 1ps

module tb;
  import rfps_pkg::*;

  // Characters beside the package ones
  localparam logic [7:0] CHAR_ONE   = 8'h31;
  localparam logic [7:0] CHAR_TWO   = 8'h32;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_FOUR  = 8'h34;

  // Unused register slots, writes must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int ERR_PRINT_MAX = 40;

  // Tracks the fade sequencer and holds the LED states still owed by the block
  class fade_scoreboard;
    logic [7:0] fast_len;
    logic [7:0] slow_len;
    logic [7:0] pwm_cnt;
    logic [7:0] last_rx;
    logic [7:0] step_idx;
    logic [7:0] tick_cnt;
    logic [2:0] pat;
    logic [1:0] phase;
    levels_t    lvl;
    out_t       expected_leds[$];
    int         errors;
    int         results_seen;
    int         beats_taken;
    int         char_beats;
    int         passes_begun;
    int         passes_done;

    function new();
      fast_len     = FAST_RESET;
      slow_len     = SLOW_RESET;
      pwm_cnt      = '0;
      last_rx      = '0;
      step_idx     = '0;
      tick_cnt     = '0;
      pat          = PAT_IDLE;
      phase        = '0;
      lvl          = '0;
      errors       = 0;
      results_seen = 0;
      beats_taken  = 0;
      char_beats   = 0;
      passes_begun = 0;
      passes_done  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
      case (idx)
        REG_FAST_STEP: fast_len = val;
        REG_SLOW_STEP: slow_len = val;
        default: ;
      endcase
    endfunction

    // Channel ramping up in a given pattern phase
    function chan_e rising(logic [2:0] p, logic [1:0] ph);
      chan_e c;
      case ({p, ph})
        {PAT_XFADE, 2'd0}, {PAT_SINGLE, 2'd0}, {PAT_GBR, 2'd1}: c = CH_RED;
        {PAT_XFADE, 2'd2}, {PAT_SINGLE, 2'd1}, {PAT_GB, 2'd1}, {PAT_GBR, 2'd2}: c = CH_GREEN;
        {PAT_XFADE, 2'd1}, {PAT_SINGLE, 2'd2}, {PAT_GB, 2'd0}, {PAT_GBR, 2'd0}: c = CH_BLUE;
        default: c = CH_NONE;
      endcase
      return c;
    endfunction

    // Channel ramping down; the single-color pattern has none
    function chan_e falling(logic [2:0] p, logic [1:0] ph);
      chan_e c;
      case ({p, ph})
        {PAT_XFADE, 2'd1}, {PAT_GBR, 2'd2}: c = CH_RED;
        {PAT_XFADE, 2'd0}, {PAT_GB, 2'd0}, {PAT_GBR, 2'd0}: c = CH_GREEN;
        {PAT_XFADE, 2'd2}, {PAT_GB, 2'd1}, {PAT_GBR, 2'd1}: c = CH_BLUE;
        default: c = CH_NONE;
      endcase
      return c;
    endfunction

    function void set_step_levels();
      chan_e up;
      chan_e dn;
      if (pat > PAT_GBR || phase > 2'd2) return;
      up = rising(pat, phase);
      dn = falling(pat, phase);
      if (up != CH_NONE) lvl[up] = step_idx;
      if (dn != CH_NONE) lvl[dn] = 8'(RAMP_STEPS_DEF - step_idx);
    endfunction

    // New pass: everything clears, pattern comes from the last character
    function void begin_pass();
      pwm_cnt  = '0;
      lvl      = '0;
      phase    = '0;
      step_idx = '0;
      tick_cnt = '0;
      if (last_rx >= CHAR_ZERO && last_rx <= CHAR_THREE) begin
        pat = 3'(last_rx - CHAR_ZERO);
        passes_begun++;
        set_step_levels();
      end else begin
        pat = PAT_IDLE;
      end
    endfunction

    // Tick bookkeeping after the pins were reported
    function void step_ramp();
      logic [7:0] len;
      logic [1:0] n_phases;
      chan_e      up;
      if (pat > PAT_GBR) return;
      len = (pat == PAT_SINGLE) ? slow_len : fast_len;
      if (len == 8'd0) len = 8'd1;
      tick_cnt = tick_cnt + 8'd1;
      if (tick_cnt < len) return;
      tick_cnt = '0;
      step_idx = step_idx + 8'd1;
      if (step_idx < RAMP_STEPS_DEF) begin
        set_step_levels();
        return;
      end
      step_idx = '0;
      // single color: the channel just ramped goes dark again
      if (pat == PAT_SINGLE) begin
        up = rising(pat, phase);
        if (up != CH_NONE) lvl[up] = '0;
      end
      n_phases = (pat == PAT_GB) ? 2'd2 : 2'd3;
      phase = phase + 2'd1;
      if (phase >= n_phases || phase == 2'd0) begin
        phase = '0;
        pat   = PAT_IDLE;
        passes_done++;
        return;
      end
      set_step_levels();
    endfunction

    function out_t led_state();
      out_t r;
      r.red_pin     = lvl[CH_RED] > pwm_cnt;
      r.green_pin   = lvl[CH_GREEN] > pwm_cnt;
      r.blue_pin    = lvl[CH_BLUE] > pwm_cnt;
      r.red_level   = lvl[CH_RED];
      r.green_level = lvl[CH_GREEN];
      r.blue_level  = lvl[CH_BLUE];
      return r;
    endfunction

    // Accepted input beat
    function void take_beat(in_t b);
      beats_taken++;
      if (b.op == OP_CHAR) begin
        last_rx = b.rx_char;
        char_beats++;
        expected_leds.push_back(led_state());
        return;
      end
      if (pat > PAT_GBR) begin_pass();
      pwm_cnt = pwm_cnt + 8'(PWM_INCREMENT_DEF);
      expected_leds.push_back(led_state());
      step_ramp();
    endfunction

    task report(string what, logic [31:0] got_v, logic [31:0] want_v);
      if (errors < ERR_PRINT_MAX)
        $display("mismatch on result %0d: %s got %0h want %0h", results_seen, what, got_v,
                 want_v);
      errors++;
    endtask

    // Accepted output beat against the oldest expected LED state
    task check_beat(out_t got);
      out_t want;
      results_seen++;
      if (expected_leds.size() == 0) begin
        report("unexpected result beat", 32'(got), '0);
        return;
      end
      want = expected_leds.pop_front();
      if (got.red_pin !== want.red_pin)
        report("red_pin", 32'(got.red_pin), 32'(want.red_pin));
      if (got.green_pin !== want.green_pin)
        report("green_pin", 32'(got.green_pin), 32'(want.green_pin));
      if (got.blue_pin !== want.blue_pin)
        report("blue_pin", 32'(got.blue_pin), 32'(want.blue_pin));
      if (got.red_level !== want.red_level)
        report("red_level", 32'(got.red_level), 32'(want.red_level));
      if (got.green_level !== want.green_level)
        report("green_level", 32'(got.green_level), 32'(want.green_level));
      if (got.blue_level !== want.blue_level)
        report("blue_level", 32'(got.blue_level), 32'(want.blue_level));
    endtask
  endclass

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  in_t                  in_data   = '0;
  logic                 in_ready;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [7:0]           cfg_data  = '0;
  int                   src_calm  = 0;
  int                   snk_calm  = 0;
  fade_scoreboard       sb;

  rgb_fade_pwm_sequencer DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Gap length: mostly none or short, a few long, with calm stretches
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Mostly ticks; characters are rare and mostly pick a pattern
  function automatic in_t rand_beat();
    in_t b;
    b.op      = OP_TICK;
    b.rx_char = 8'($urandom);
    if ($urandom_range(0, 63) == 0) begin
      b.op = OP_CHAR;
      if ($urandom_range(0, 99) < 85) b.rx_char = CHAR_ZERO + 8'($urandom_range(0, 3));
    end
    return b;
  endfunction

  // Present one input beat; valid stays high into the next call when no gap follows
  task automatic send_beat(in_t b);
    int gap;
    gap = pick_gap(src_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_tick();
    in_t b;
    b.op      = OP_TICK;
    b.rx_char = 8'($urandom);
    send_beat(b);
  endtask

  task automatic send_char(logic [7:0] c);
    in_t b;
    b.op      = OP_CHAR;
    b.rx_char = c;
    send_beat(b);
  endtask

  // Drop valid and wait for every owed result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_leds.size() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_idx   <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_step_lengths(logic [7:0] fast_v, logic [7:0] slow_v);
    write_cfg(REG_FAST_STEP, fast_v);
    write_cfg(REG_SLOW_STEP, slow_v);
  endtask

  task automatic run_random(int n);
    repeat (n) send_beat(rand_beat());
    drain();
  endtask

  // Beat monitor feeding the scoreboard
  always @(posedge clk) begin
    if (cfg_valid && cfg_ready) sb.write_reg(cfg_idx, cfg_data);
    if (in_valid && in_ready) sb.take_beat(in_data);
    if (out_valid && out_ready) sb.check_beat(out_data);
  end

  // Receiver with random stalls
  initial begin
    int stall;
    @(posedge clk);
    forever begin
      stall = pick_gap(snk_calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout with %0d results outstanding", sb.expected_leds.size());
    $display("[rgb_fade_pwm_sequencer] ERROR");
    $finish;
  end

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle ticks, characters that select nothing, pattern start, characters sent mid-pass
    send_tick();
    send_char(8'hFF);
    send_tick();
    send_char(8'h00);
    send_tick();
    send_char(CHAR_SLASH);
    send_tick();
    send_char(CHAR_FOUR);
    send_tick();
    send_char(CHAR_ZERO);
    repeat (3) send_tick();
    send_char(CHAR_ONE);
    repeat (2) send_tick();
    send_char(CHAR_TWO);
    send_tick();
    send_char(CHAR_THREE);
    repeat (2) send_tick();
    drain();

    // Shortest steps so the fade advances every tick
    set_step_lengths(8'd1, 8'd1);
    run_random(450);

    // Longest steps, plus writes to the unused slots
    set_step_lengths(8'd255, 8'd255);
    write_cfg(REG_SPARE_A, 8'($urandom));
    write_cfg(REG_SPARE_B, 8'($urandom));
    run_random(60);

    // Zero length behaves as one
    set_step_lengths(8'd0, 8'd0);
    run_random(450);

    set_step_lengths(8'($urandom_range(1, 3)), 8'($urandom_range(1, 3)));
    run_random(200);

    repeat (4) @(posedge clk);
    $display("covered %0d input beats (%0d characters), %0d results checked",
             sb.beats_taken, sb.char_beats, sb.results_seen);
    $display("fade passes started %0d, completed %0d, step lengths 0 to 255, %0d mismatches",
             sb.passes_begun, sb.passes_done, sb.errors);
    if (sb.errors == 0) begin
      $display("[rgb_fade_pwm_sequencer] OK");
    end else begin
      $display("[rgb_fade_pwm_sequencer] ERROR");
    end
    $finish;
  end

endmodule
